[rtl/sensor_min_max_normalizer_core_assert.svh]
// Assertion macros shared by the sensor normaliser RTL.
// Included by modules that check their own control logic; no other dependencies.
`ifndef SENSOR_MIN_MAX_NORMALIZER_CORE_ASSERT_SVH
`define SENSOR_MIN_MAX_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMMN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smmn: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SMMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smmn: next-cycle check failed");

`endif

[rtl/smmn_pkg.sv]
// Shared types and constants for the sensor min/max normaliser.
// No dependencies; used by every RTL file but the assertion macro header.
package smmn_pkg;

    localparam int CHANNELS_DEF    = 12;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int CH_W            = 4;
    localparam int LEVEL_W         = 16;
    localparam int FRAC_BITS       = 15;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1) << FRAC_BITS;

    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    typedef enum logic [1:0] {
        KIND_CAL,
        KIND_NORM,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [CH_W-1:0]  channel;
    } t_tag;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_EMIT
    } t_back_state;

endpackage

[rtl/smmn_if.sv]
// Handshake channels of the sensor normaliser: sample input and level output.
// Depends on smmn_pkg for field widths.
interface smmn_in_if #(
    parameter int SAMPLE_BITS = smmn_pkg::SAMPLE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [smmn_pkg::CH_W-1:0]   channel;
    logic [SAMPLE_BITS-1:0]      raw_sample;

    modport source (output valid, operation, channel, raw_sample, input ready);
    modport sink   (input valid, operation, channel, raw_sample, output ready);
endinterface

interface smmn_out_if;
    logic                          valid;
    logic                          ready;
    logic [smmn_pkg::CH_W-1:0]     out_channel;
    logic [smmn_pkg::LEVEL_W-1:0]  level;
    logic                          uncalibrated;

    modport source (output valid, out_channel, level, uncalibrated, input ready);
    modport sink   (input valid, out_channel, level, uncalibrated, output ready);
endinterface

[rtl/sensor_min_max_normalizer_core.sv]
// Sensor min/max normaliser, top level.
// Depends on smmn_pkg, smmn_if, smmn_front and smmn_back.
//
// Usage: i_in carries beats of {operation, channel, raw_sample}. A calibrate beat widens
// the stored low and high marks of its channel and produces nothing; a calibrate beat for
// a channel that does not exist is dropped. A normalise beat produces one beat on o_out:
// the channel, the level (raw - low) / (high - low) in unsigned Q1.15, saturated to 0..1.0,
// and an uncalibrated flag when high is not above low (or the channel does not exist).
// The front end takes beats into a two-entry command queue, so i_in accepts up to two
// beats while the back end is busy; once both entries are taken i_in.ready falls.
// Back-end steps: a calibrate beat goes through IDLE and DECIDE, where the marks are written.
// A normalise beat that saturates or has uncalibrated marks goes IDLE, DECIDE, EMIT to the
// output register; one that needs the divider also passes DIVIDE, the radix-2 divider giving
// one quotient bit per cycle over 15 bits. The back end handles one command at a time.
// Reset (synchronous, active low) empties the queue and the output register and returns
// every channel to low mark full scale, high mark zero, through per-channel valid bits.
// When o_out is stalled the result holds in the output register; the back end then waits
// with its next result, the queue fills and i_in.ready falls.
module sensor_min_max_normalizer_core #(
    parameter int CHANNELS    = smmn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = smmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smmn_in_if.sink     i_in,
    smmn_out_if.source  o_out
);
    logic                    cmd_valid;
    smmn_pkg::t_tag          cmd_tag;
    logic [SAMPLE_BITS-1:0]  cmd_raw;
    logic                    cmd_pop;

    smmn_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd_tag   (cmd_tag),
        .o_cmd_raw   (cmd_raw),
        .i_cmd_pop   (cmd_pop)
    );

    smmn_back #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_tag   (cmd_tag),
        .i_cmd_raw   (cmd_raw),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

[rtl/smmn_front.sv]
// Front end: accepts sample beats, classifies them and queues commands for the back end.
// Depends on smmn_pkg and smmn_in_if.
module smmn_front #(
    parameter int CHANNELS    = smmn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = smmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    smmn_in_if.sink                 i_in,
    output logic                    o_cmd_valid,
    output smmn_pkg::t_tag          o_cmd_tag,
    output logic [SAMPLE_BITS-1:0]  o_cmd_raw,
    input  logic                    i_cmd_pop
);
    localparam int PTR_W = (smmn_pkg::QUEUE_DEPTH > 1) ? $clog2(smmn_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(smmn_pkg::QUEUE_DEPTH + 1);

    smmn_pkg::t_tag          r_q_tag [smmn_pkg::QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0]  r_q_raw [smmn_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]        r_count, n_count;

    logic            accept;
    logic            ch_ok;
    logic            push;
    smmn_pkg::t_tag  in_tag;

    assign i_in.ready = (r_count != CNT_W'(smmn_pkg::QUEUE_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign ch_ok      = (32'(i_in.channel) < 32'(CHANNELS));

    // A calibrate beat for a channel that does not exist is simply dropped.
    assign push = accept && !((i_in.operation == smmn_pkg::OP_CALIBRATE) && !ch_ok);

    always_comb begin
        in_tag.channel = i_in.channel;
        priority if (!ch_ok) begin
            in_tag.kind = smmn_pkg::KIND_BAD;
        end else if (i_in.operation == smmn_pkg::OP_NORMALIZE) begin
            in_tag.kind = smmn_pkg::KIND_NORM;
        end else begin
            in_tag.kind = smmn_pkg::KIND_CAL;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(smmn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(smmn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push, i_cmd_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_tag[r_wr_ptr] <= in_tag;
            r_q_raw[r_wr_ptr] <= i_in.raw_sample;
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd_tag   = r_q_tag[r_rd_ptr];
    assign o_cmd_raw   = r_q_raw[r_rd_ptr];

endmodule

[rtl/smmn_div.sv]
// Radix-2 restoring divider giving floor(above * 2^FRAC_BITS / span) for above < span.
// Depends on smmn_pkg; one quotient bit per cycle.
module smmn_div #(
    parameter int SAMPLE_BITS = smmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [SAMPLE_BITS-1:0]            i_above,
    input  logic [SAMPLE_BITS-1:0]            i_span,
    output logic                              o_done,
    output logic [smmn_pkg::FRAC_BITS-1:0]    o_quot
);
    localparam int QB    = smmn_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(QB + 1);

    logic [SAMPLE_BITS-1:0]  r_rem;
    logic [SAMPLE_BITS-1:0]  r_span;
    logic [QB-1:0]           r_quot;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [SAMPLE_BITS:0]    shifted;
    logic [SAMPLE_BITS:0]    diff;
    logic                    ge;

    // The remainder stays below the span, so the shifted value fits in one extra bit.
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_span};
    assign ge      = (shifted >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_above;
            r_span <= i_span;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            r_quot <= {r_quot[QB-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/smmn_back.sv]
// Back end: mark store, calibration update, level computation and output register.
// Depends on smmn_pkg, smmn_out_if, smmn_div and the assertion macro header.
`include "sensor_min_max_normalizer_core_assert.svh"

module smmn_back #(
    parameter int CHANNELS    = smmn_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = smmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  smmn_pkg::t_tag          i_cmd_tag,
    input  logic [SAMPLE_BITS-1:0]  i_cmd_raw,
    output logic                    o_cmd_pop,
    smmn_out_if.source              o_out
);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SB    = SAMPLE_BITS;
    localparam int LW    = smmn_pkg::LEVEL_W;

    // Mark store: {high, low} per channel; an unwritten entry reads as low full scale, high zero.
    logic [2*SB-1:0]  r_mark_mem [CHANNELS];
    logic [CHANNELS-1:0] r_mark_vld;

    smmn_pkg::t_back_state r_state, n_state;

    smmn_pkg::t_kind         r_kind;
    logic [smmn_pkg::CH_W-1:0] r_ch;
    logic [SB-1:0]           r_raw;
    logic [IDX_W-1:0]        r_idx;
    logic [2*SB-1:0]         r_rd_mark;
    logic                    r_rd_ok;
    logic [LW-1:0]           r_res_level;
    logic                    r_res_uncal;

    logic                       r_out_valid;
    logic [smmn_pkg::CH_W-1:0]  r_out_ch;
    logic [LW-1:0]              r_out_level;
    logic                       r_out_uncal;

    logic [smmn_pkg::CH_W+IDX_W-1:0] ch_ext;
    logic [IDX_W-1:0]        cmd_idx;
    logic [SB-1:0]           lo, hi, new_lo, new_hi;
    logic                    uncal, at_low, at_high;
    logic                    mark_we, div_start, out_load, out_free;
    logic                    div_done;
    logic [smmn_pkg::FRAC_BITS-1:0] div_quot;

    assign ch_ext  = {{IDX_W{1'b0}}, i_cmd_tag.channel};
    assign cmd_idx = ch_ext[IDX_W-1:0];

    assign lo      = r_rd_ok ? r_rd_mark[SB-1:0]    : {SB{1'b1}};
    assign hi      = r_rd_ok ? r_rd_mark[2*SB-1:SB] : {SB{1'b0}};
    assign new_lo  = (r_raw < lo) ? r_raw : lo;
    assign new_hi  = (r_raw > hi) ? r_raw : hi;
    assign uncal   = (hi <= lo);
    assign at_low  = (r_raw <= lo);
    assign at_high = (r_raw >= hi);
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smmn_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd_tag.kind == smmn_pkg::KIND_BAD) ?
                              smmn_pkg::ST_EMIT : smmn_pkg::ST_DECIDE;
                end
            end
            smmn_pkg::ST_DECIDE: begin
                priority if (r_kind == smmn_pkg::KIND_CAL) begin
                    n_state = smmn_pkg::ST_IDLE;
                end else if (uncal || at_low || at_high) begin
                    n_state = smmn_pkg::ST_EMIT;
                end else begin
                    n_state = smmn_pkg::ST_DIVIDE;
                end
            end
            smmn_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    n_state = smmn_pkg::ST_EMIT;
                end
            end
            smmn_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = smmn_pkg::ST_IDLE;
                end
            end
            default: n_state = smmn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == smmn_pkg::ST_IDLE) && i_cmd_valid;
        mark_we   = (r_state == smmn_pkg::ST_DECIDE) && (r_kind == smmn_pkg::KIND_CAL);
        div_start = (r_state == smmn_pkg::ST_DECIDE) && (r_kind != smmn_pkg::KIND_CAL) &&
                    !(uncal || at_low || at_high);
        out_load  = (r_state == smmn_pkg::ST_EMIT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smmn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_vld <= '0;
        end else if (mark_we) begin
            r_mark_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[r_idx] <= {new_hi, new_lo};
        end
        if (o_cmd_pop && (i_cmd_tag.kind != smmn_pkg::KIND_BAD)) begin
            r_rd_mark <= r_mark_mem[cmd_idx];
            r_rd_ok   <= r_mark_vld[cmd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_kind      <= i_cmd_tag.kind;
            r_ch        <= i_cmd_tag.channel;
            r_raw       <= i_cmd_raw;
            r_idx       <= cmd_idx;
            r_res_level <= smmn_pkg::LEVEL_ZERO;
            r_res_uncal <= 1'b1;
        end else if (r_state == smmn_pkg::ST_DECIDE) begin
            r_res_uncal <= uncal;
            priority if (uncal || at_low) begin
                r_res_level <= smmn_pkg::LEVEL_ZERO;
            end else if (at_high) begin
                r_res_level <= smmn_pkg::LEVEL_ONE;
            end else begin
                r_res_level <= smmn_pkg::LEVEL_ZERO;
            end
        end else if (div_done) begin
            r_res_level <= LW'(div_quot);
        end
    end

    smmn_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_above (r_raw - lo),
        .i_span  (hi - lo),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch    <= r_ch;
            r_out_level <= r_res_level;
            r_out_uncal <= r_res_uncal;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_channel  = r_out_ch;
    assign o_out.level        = r_out_level;
    assign o_out.uncalibrated = r_out_uncal;

    `SMMN_ASSERT_NOW(a_done_in_divide, i_clk, i_rst_n, div_done, r_state == smmn_pkg::ST_DIVIDE)
    `SMMN_ASSERT_NEXT(a_start_enters_divide, i_clk, i_rst_n, div_start, r_state == smmn_pkg::ST_DIVIDE)
    `SMMN_ASSERT_NOW(a_level_in_range, i_clk, i_rst_n, r_out_valid, r_out_level <= smmn_pkg::LEVEL_ONE)
    `SMMN_ASSERT_NOW(a_uncal_level_zero, i_clk, i_rst_n, r_out_valid && r_out_uncal, r_out_level == smmn_pkg::LEVEL_ZERO)

endmodule

[verif/sensor_min_max_normalizer_core_checker.sv]
// Scoreboard for the sensor min/max normaliser: watches both handshake channels,
// tracks per-channel calibration marks and compares every level beat in order.
// Depends on smmn_pkg for widths, operation codes and level constants.
module sensor_min_max_normalizer_core_checker
    import smmn_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic                   i_in_operation,
    input  logic [CH_W-1:0]        i_in_channel,
    input  logic [SAMPLE_BITS-1:0] i_in_raw_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [CH_W-1:0]        i_out_channel,
    input  logic [LEVEL_W-1:0]     i_out_level,
    input  logic                   i_out_uncalibrated,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic               uncalibrated;
    } t_level_beat;

    logic [SAMPLE_BITS-1:0] cal_min [CHANNELS];
    logic [SAMPLE_BITS-1:0] cal_max [CHANNELS];
    t_level_beat            expected_levels [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    // Position of the sample between the channel's marks, truncated the way
    // a restoring divider leaves the quotient.
    function automatic t_level_beat predict_level(logic [CH_W-1:0] ch,
                                                  logic [SAMPLE_BITS-1:0] raw);
        t_level_beat            beat;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [31:0]            num;
        logic [31:0]            den;
        beat.channel      = ch;
        beat.level        = LEVEL_ZERO;
        beat.uncalibrated = 1'b1;
        if (ch < CHANNELS) begin
            lo = cal_min[ch];
            hi = cal_max[ch];
            if (hi > lo) begin
                beat.uncalibrated = 1'b0;
                if (raw >= hi) begin
                    beat.level = LEVEL_ONE;
                end else if (raw > lo) begin
                    num        = (32'(raw) - 32'(lo)) << FRAC_BITS;
                    den        = 32'(hi) - 32'(lo);
                    beat.level = LEVEL_W'(num / den);
                end
            end
        end
        return beat;
    endfunction

    always @(posedge i_clk) begin : track
        t_level_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                cal_min[i] = '1;
                cal_max[i] = '0;
            end
            expected_levels.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in_operation == OP_CALIBRATE) begin
                    if (i_in_channel < CHANNELS) begin
                        if (i_in_raw_sample > cal_max[i_in_channel])
                            cal_max[i_in_channel] = i_in_raw_sample;
                        if (i_in_raw_sample < cal_min[i_in_channel])
                            cal_min[i_in_channel] = i_in_raw_sample;
                    end
                end else begin
                    expected_levels.push_back(predict_level(i_in_channel, i_in_raw_sample));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch($sformatf("level beat for channel %0d with none expected",
                                              i_out_channel));
                end else begin
                    want = expected_levels.pop_front();
                    if (i_out_channel !== want.channel)
                        report_mismatch($sformatf("channel %0d, expected %0d",
                                                  i_out_channel, want.channel));
                    if (i_out_level !== want.level)
                        report_mismatch($sformatf("level %0d on channel %0d, expected %0d",
                                                  i_out_level, want.channel, want.level));
                    if (i_out_uncalibrated !== want.uncalibrated)
                        report_mismatch($sformatf("uncalibrated %0b on channel %0d, expected %0b",
                                                  i_out_uncalibrated, want.channel,
                                                  want.uncalibrated));
                end
            end
        end
        o_pending <= expected_levels.size();
    end

endmodule

[verif/sensor_min_max_normalizer_core_tb.sv]
// Top of the sensor min/max normaliser testbench: clock, reset, sample stimulus
// and receiver back-pressure; the checker module does all the comparing.
// Depends on smmn_pkg, smmn_if, the core RTL and the checker.
module sensor_min_max_normalizer_core_tb;
    import smmn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS      = CHANNELS_DEF;
    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int FULL_SCALE    = (1 << SAMPLE_BITS) - 1;
    localparam int BEATS_PER_SET = 340;
    localparam int HOLD_BEATS    = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int idle_pct;
    int stall_pct;
    bit hold_wanted;
    bit hold_done;
    int fail_count;
    int pending;
    int centre [CHANNELS];
    int reach  [CHANNELS];

    smmn_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
    smmn_out_if                             out_if ();

    always #5 i_clk = ~i_clk;

    sensor_min_max_normalizer_core #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sensor_min_max_normalizer_core_checker #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_if.valid),
        .i_in_ready         (in_if.ready),
        .i_in_operation     (in_if.operation),
        .i_in_channel       (in_if.channel),
        .i_in_raw_sample    (in_if.raw_sample),
        .i_out_valid        (out_if.valid),
        .i_out_ready        (out_if.ready),
        .i_out_channel      (out_if.out_channel),
        .i_out_level        (out_if.level),
        .i_out_uncalibrated (out_if.uncalibrated),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Called just after a rising edge; returns at the edge that accepts the beat.
    task automatic send_beat(logic op, int ch, int raw);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.operation  <= op;
        in_if.channel    <= CH_W'(ch);
        in_if.raw_sample <= SAMPLE_BITS'(raw);
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    function automatic int sample_near(int ch, int spread);
        int raw;
        raw = centre[ch] + $urandom_range(2 * spread) - spread;
        if (raw < 0) raw = 0;
        if (raw > FULL_SCALE) raw = FULL_SCALE;
        return raw;
    endfunction

    // Channels 0 to 9 are calibrated around a centre of their own, so their
    // marks settle and later samples land below, inside and above them.
    // Channel 10 keeps equal marks and channel 11 is never calibrated here.
    task automatic random_beat();
        int pick;
        int ch;
        int raw;
        pick = $urandom_range(99);
        if (pick < 40) begin
            if ($urandom_range(19) == 0) begin
                send_beat(OP_CALIBRATE, $urandom_range(15, CHANNELS),
                          $urandom_range(FULL_SCALE));
            end else begin
                ch = $urandom_range(9);
                send_beat(OP_CALIBRATE, ch, sample_near(ch, reach[ch]));
            end
        end else begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_beat(OP_NORMALIZE, $urandom_range(15, CHANNELS),
                          $urandom_range(FULL_SCALE));
            end else if (pick < 10) begin
                send_beat(OP_NORMALIZE, $urandom_range(11, 10), $urandom_range(FULL_SCALE));
            end else begin
                ch  = $urandom_range(9);
                raw = ($urandom_range(99) < 15) ? $urandom_range(FULL_SCALE)
                                                : sample_near(ch, 2 * reach[ch] + 1);
                send_beat(OP_NORMALIZE, ch, raw);
            end
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        int idle_set  [4] = '{0, 60, 0, 33};
        int stall_set [4] = '{0, 0, 60, 33};
        int spreads   [5] = '{1, 3, 40, 600, 2047};
        in_if.valid      <= 1'b0;
        in_if.operation  <= OP_CALIBRATE;
        in_if.channel    <= '0;
        in_if.raw_sample <= '0;
        i_rst_n          <= 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_wanted = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            centre[i] = $urandom_range(FULL_SCALE);
            reach[i]  = spreads[i % 5];
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset every channel is uncalibrated.
        send_beat(OP_NORMALIZE, 0, 2048);
        // Full-scale marks on channel 0, then both ends and the steps next to them.
        send_beat(OP_CALIBRATE, 0, 0);
        send_beat(OP_CALIBRATE, 0, FULL_SCALE);
        send_beat(OP_NORMALIZE, 0, 0);
        send_beat(OP_NORMALIZE, 0, FULL_SCALE);
        send_beat(OP_NORMALIZE, 0, 1);
        send_beat(OP_NORMALIZE, 0, FULL_SCALE - 1);
        send_beat(OP_NORMALIZE, 0, 2730);
        // A single calibration leaves the marks equal.
        send_beat(OP_CALIBRATE, 10, 1234);
        send_beat(OP_NORMALIZE, 10, 1234);
        send_beat(OP_NORMALIZE, 10, 0);
        // Channels that do not exist: calibration ignored, level flagged.
        send_beat(OP_CALIBRATE, 15, 100);
        send_beat(OP_NORMALIZE, 15, 100);
        send_beat(OP_NORMALIZE, 12, FULL_SCALE);
        // Narrowest span of one step.
        send_beat(OP_CALIBRATE, 1, 100);
        send_beat(OP_CALIBRATE, 1, 101);
        send_beat(OP_NORMALIZE, 1, 100);
        send_beat(OP_NORMALIZE, 1, 101);
        send_beat(OP_NORMALIZE, 1, 50);
        send_beat(OP_NORMALIZE, 1, 200);
        // Span of three, where the quotient truncates.
        send_beat(OP_CALIBRATE, 2, 2003);
        send_beat(OP_CALIBRATE, 2, 2000);
        send_beat(OP_NORMALIZE, 2, 2001);
        send_beat(OP_NORMALIZE, 2, 2002);

        for (int set = 0; set < 4; set++) begin
            idle_pct  = idle_set[set];
            stall_pct = stall_set[set];
            repeat (BEATS_PER_SET) random_beat();
        end

        // Keep offering beats while the receiver holds off, so the queue fills.
        idle_pct    = 0;
        stall_pct   = 0;
        hold_wanted = 1'b1;
        repeat (HOLD_BEATS) random_beat();

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS sensor_min_max_normalizer_core");
        end else begin
            $display("FAIL sensor_min_max_normalizer_core");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL sensor_min_max_normalizer_core");
        $finish;
    end

endmodule
